/* rtl/core/qdmw_pkg.sv */
// ---------------------------------------------------------------------------
// qdmw_pkg
// Shared widths, register indexes and result type of the QR data module walker.
// ---------------------------------------------------------------------------
`default_nettype none

package qdmw_pkg;

   localparam int ROW_W     = 8;
   localparam int COL_W     = 8;
   localparam int BIT_IDX_W = 15;
   localparam int VER_W     = 6;
   localparam int ACNT_W    = 3;
   localparam int APOS_W    = 56;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = APOS_W;

   localparam int MAX_ALIGN_POSITIONS = 7;
   localparam int MAX_VERSION         = 40;
   localparam int VERSION_WITH_INFO   = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_VERSION         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_POSITIONS = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0]     module_row;
      logic [COL_W-1:0]     module_col;
      logic [BIT_IDX_W-1:0] bit_index;
      logic                 finished;
      logic                 last;
   } rsp_item_type;

endpackage

`default_nettype wire

/* rtl/core/qdmw_if.sv */
// ---------------------------------------------------------------------------
// qdmw request / response channels
// Valid/ready channels for walker commands and emitted data module positions.
// ---------------------------------------------------------------------------
`default_nettype none

interface qdmw_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface qdmw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [qdmw_pkg::ROW_W-1:0]     module_row;
   logic [qdmw_pkg::COL_W-1:0]     module_col;
   logic [qdmw_pkg::BIT_IDX_W-1:0] bit_index;
   logic                           finished;
   logic                           last;

   modport source (output valid, output module_row, output module_col, output bit_index,
                   output finished, output last, input ready);
   modport sink   (input valid, input module_row, input module_col, input bit_index,
                   input finished, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/qr_data_module_walker.sv */
// ---------------------------------------------------------------------------
// qr_data_module_walker
// Emits the row/column of every data module of a QR symbol in zigzag order.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one command per transaction: restart=1 puts the walker at
//   the bottom-right corner and produces no result; restart=0 visits one
//   column pair at the current row and produces 0, 1 or 2 results on rsp_bus
//   (one per transaction, last set on the final one). After the walk ends,
//   each advance produces a single result with finished=1 and the total
//   module count in bit_index.
//   The function-module test is combinational from the csr registers
//   (version, alignment count, packed alignment centres); write them only
//   while the block is idle.
//   A result appears in the cycle after its command is accepted.
//   Throughput: one command per cycle while each yields at most one result
//   and rsp_bus.ready is high; a command yielding two results fills the
//   two-entry result buffer, so the next command waits until one is taken.
//   Stalls: rsp_bus.ready low holds the buffered results; req_bus.ready drops
//   once the buffer cannot take a full command's results.
//   Reset: synchronous; walker ends up in the finished state with version 1
//   and no alignment squares; the buffer is emptied.
// ---------------------------------------------------------------------------
`default_nettype none

module qr_data_module_walker (
   input  wire                                clock,
   input  wire                                reset,
   qdmw_req_if.sink                           req_bus,
   qdmw_rsp_if.source                         rsp_bus,
   input  wire                                csr_we,
   input  wire  [qdmw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [qdmw_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import qdmw_pkg::*;

   // configuration
   logic [VER_W-1:0]  version_ff;
   logic [ACNT_W-1:0] align_count_ff;
   logic [APOS_W-1:0] align_pos_ff;

   // walker state
   logic [ROW_W-1:0]     walk_row_ff, walk_row_in;
   logic [COL_W-1:0]     walk_col_ff, walk_col_in;
   logic                 walk_upward_ff, walk_upward_in;
   logic [BIT_IDX_W-1:0] bit_count_ff, bit_count_in;
   logic                 walk_finished_ff, walk_finished_in;

   // result buffer
   rsp_item_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]   cnt_ff, cnt_in;

   logic req_acc, rsp_acc;
   logic [VER_W-1:0]  ver_eff;
   logic [ROW_W-1:0]  sym_n;
   logic [ACNT_W-1:0] cnt_eff;
   logic              info_en;
   logic [COL_W-1:0]  col_eff, col_left;
   logic              free0, free1;
   logic signed [9:0] row_s;
   logic signed [9:0] col_s;
   logic              up_nx;
   rsp_item_type      res0, res1;
   logic [1:0]        res_cnt;

   function automatic logic is_func(
      input logic [ROW_W-1:0]  r,
      input logic [COL_W-1:0]  c,
      input logic [ROW_W-1:0]  n,
      input logic              info,
      input logic [ACNT_W-1:0] acnt,
      input logic [APOS_W-1:0] apos
   );
      logic [MAX_ALIGN_POSITIONS-1:0] row_hit;
      logic [MAX_ALIGN_POSITIONS-1:0] col_hit;
      logic [7:0] ap;
      logic       hit;
      hit = 1'b0;
      for (int i = 0; i < MAX_ALIGN_POSITIONS; i++) begin
         ap = apos[8*i +: 8];
         row_hit[i] = ({1'b0, r} + 9'd2 >= {1'b0, ap}) && ({1'b0, r} <= {1'b0, ap} + 9'd2);
         col_hit[i] = ({1'b0, c} + 9'd2 >= {1'b0, ap}) && ({1'b0, c} <= {1'b0, ap} + 9'd2);
      end
      for (int i = 0; i < MAX_ALIGN_POSITIONS; i++) begin
         for (int j = 0; j < MAX_ALIGN_POSITIONS; j++) begin
            // skip the three squares that would sit on the finders
            if (ACNT_W'(i) < acnt && ACNT_W'(j) < acnt
                && !(i == 0 && j == 0)
                && !(ACNT_W'(i) == acnt - 3'd1 && j == 0)
                && !(i == 0 && ACNT_W'(j) == acnt - 3'd1)
                && row_hit[i] && col_hit[j]) begin
               hit = 1'b1;
            end
         end
      end
      if (r < 8'd9 && c < 8'd9) hit = 1'b1;
      if (r >= n - 8'd8 && c < 8'd9) hit = 1'b1;
      if (r < 8'd9 && c >= n - 8'd8) hit = 1'b1;
      if (c == 8'd6 && r >= 8'd8 && r <= n - 8'd9) hit = 1'b1;
      if (r == 8'd6 && c >= 8'd8 && c <= n - 8'd9) hit = 1'b1;
      if (info) begin
         if (r >= n - 8'd11 && r <= n - 8'd9 && c < 8'd6) hit = 1'b1;
         if (r < 8'd6 && c >= n - 8'd11 && c <= n - 8'd9) hit = 1'b1;
      end
      return hit;
   endfunction

   assign req_acc = req_bus.valid && req_bus.ready;
   assign rsp_acc = rsp_bus.valid && rsp_bus.ready;

   assign req_bus.ready      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_bus.ready);
   assign rsp_bus.valid      = (cnt_ff != 2'd0);
   assign rsp_bus.module_row = slot0_ff.module_row;
   assign rsp_bus.module_col = slot0_ff.module_col;
   assign rsp_bus.bit_index  = slot0_ff.bit_index;
   assign rsp_bus.finished   = slot0_ff.finished;
   assign rsp_bus.last       = slot0_ff.last;

   // effective geometry
   always_comb begin
      ver_eff = version_ff;
      if (ver_eff == '0) ver_eff = VER_W'(1);
      if (ver_eff > VER_W'(MAX_VERSION)) ver_eff = VER_W'(MAX_VERSION);
      sym_n   = ROW_W'({ver_eff, 2'b00}) + 8'd17;
      info_en = (ver_eff >= VER_W'(VERSION_WITH_INFO));
      cnt_eff = align_count_ff;
      if (align_count_ff > ACNT_W'(MAX_ALIGN_POSITIONS)) cnt_eff = ACNT_W'(MAX_ALIGN_POSITIONS);
   end

   assign col_eff  = (walk_col_ff == 8'd6) ? 8'd5 : walk_col_ff;
   assign col_left = col_eff - 8'd1;
   assign free0 = !is_func(walk_row_ff, col_eff, sym_n, info_en, cnt_eff, align_pos_ff);
   assign free1 = (col_eff != 8'd0)
                  && !is_func(walk_row_ff, col_left, sym_n, info_en, cnt_eff, align_pos_ff);

   // restart, finished result or one zigzag step
   always_comb begin
      walk_row_in      = walk_row_ff;
      walk_col_in      = walk_col_ff;
      walk_upward_in   = walk_upward_ff;
      bit_count_in     = bit_count_ff;
      walk_finished_in = walk_finished_ff;
      res0    = '0;
      res1    = '0;
      res_cnt = 2'd0;
      row_s   = '0;
      col_s   = '0;
      up_nx   = walk_upward_ff;
      if (req_bus.restart) begin
         walk_row_in      = sym_n - 8'd1;
         walk_col_in      = sym_n - 8'd1;
         walk_upward_in   = 1'b1;
         bit_count_in     = '0;
         walk_finished_in = 1'b0;
      end else if (walk_finished_ff) begin
         res0.bit_index = bit_count_ff;
         res0.finished  = 1'b1;
         res0.last      = 1'b1;
         res_cnt        = 2'd1;
      end else begin
         res0.module_row = walk_row_ff;
         res0.module_col = free0 ? col_eff : col_left;
         res0.bit_index  = bit_count_ff;
         res0.last       = !(free0 && free1);
         res1.module_row = walk_row_ff;
         res1.module_col = col_left;
         res1.bit_index  = bit_count_ff + 15'd1;
         res1.last       = 1'b1;
         res_cnt         = {1'b0, free0} + {1'b0, free1};
         bit_count_in    = bit_count_ff + BIT_IDX_W'(res_cnt);

         row_s = walk_upward_ff ? $signed({2'b00, walk_row_ff}) - 10'sd1
                                : $signed({2'b00, walk_row_ff}) + 10'sd1;
         col_s = $signed({2'b00, col_eff});
         if (row_s < 10'sd0 || row_s >= $signed({2'b00, sym_n})) begin
            up_nx = !walk_upward_ff;
            col_s = col_s - 10'sd2;
            row_s = up_nx ? row_s - 10'sd1 : row_s + 10'sd1;
            if (row_s < 10'sd0) row_s = 10'sd0;
            if (row_s > 10'sd255) row_s = 10'sd255;
         end
         if (col_s <= 10'sd0) begin
            walk_finished_in = 1'b1;
            col_s = 10'sd0;
         end
         if (col_s == 10'sd6) col_s = 10'sd5;
         walk_upward_in = up_nx;
         walk_row_in    = row_s[7:0];
         walk_col_in    = col_s[7:0];
      end
   end

   // result buffer next state
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (req_acc) begin
         slot0_in = res0;
         slot1_in = res1;
         cnt_in   = res_cnt;
      end else if (rsp_acc) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff           <= '0;
         walk_row_ff      <= '0;
         walk_col_ff      <= '0;
         walk_upward_ff   <= 1'b1;
         bit_count_ff     <= '0;
         walk_finished_ff <= 1'b1;
      end else begin
         cnt_ff <= cnt_in;
         if (req_acc) begin
            walk_row_ff      <= walk_row_in;
            walk_col_ff      <= walk_col_in;
            walk_upward_ff   <= walk_upward_in;
            bit_count_ff     <= bit_count_in;
            walk_finished_ff <= walk_finished_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff     <= VER_W'(1);
         align_count_ff <= '0;
         align_pos_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERSION:         version_ff     <= csr_wdata[VER_W-1:0];
            CSR_ALIGN_COUNT:     align_count_ff <= csr_wdata[ACNT_W-1:0];
            CSR_ALIGN_POSITIONS: align_pos_ff   <= csr_wdata[APOS_W-1:0];
            default: ;
         endcase
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("result buffer overfilled");

   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_bus.restart |=> cnt_ff == 2'd0)
      else $error("restart produced a result");

   a_fin_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.finished |-> rsp_bus.module_row == '0
                                            && rsp_bus.module_col == '0 && rsp_bus.last)
      else $error("finished result carries a position");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last
                         && slot1_ff.bit_index == slot0_ff.bit_index + 15'd1)
      else $error("pair results out of order");

endmodule

`default_nettype wire
